>>> hw/rtl/lpf_pkg.sv
// Shared types and constants for the LED pulse and flash controller.
// No dependencies; every other file in this block refers to it by scoped names.
package lpf_pkg;

  localparam int LAMP_COUNT  = 4;
  localparam int LAMP_IDX_W  = 2;
  localparam int FLASH_PERIOD = 10;
  localparam int PULSE_TICKS = 3;
  localparam int TMO_W       = 5;
  localparam int MASK_W      = 4;

  // Lamp roles and alarm mask bit positions.
  localparam logic [LAMP_IDX_W-1:0] ALARM_LAMP = 2'd3;
  localparam logic [LAMP_IDX_W-1:0] DUMP_LAMP  = 2'd2;
  localparam int GPS_BIT  = 1;
  localparam int MAIN_BIT = 2;

  typedef logic signed [TMO_W-1:0] tmo_t;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_PULSE    = 3'd1,
    KIND_STEADY   = 3'd2,
    KIND_GPS      = 3'd3,
    KIND_MAIN     = 3'd4,
    KIND_BATTERY  = 3'd5,
    KIND_SET_MODE = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_DUMP   = 2'd1,
    MODE_DONE   = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e                 kind;
    logic [LAMP_IDX_W-1:0] led_index;
    logic                  alarm_level;
    logic [1:0]            new_mode;
  } item_t;

endpackage

>>> hw/rtl/led_pulse_flash_controller_core.sv
// LED pulse and flash controller, top level.
// Path: the input word is held in the input stage register, then the result is registered
// in the lamp bits register; a stalled output holds the word in the input stage.
// Throughput: one word per cycle while the output is not stalled; the lamp update is one pass of logic per word.
// Reset: asynchronous, active low; all lamps off, timers and alarm mask zero,
// normal mode, both channels empty.
module led_pulse_flash_controller_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [1:0] led_index_i,
  input  logic       alarm_level_i,
  input  logic [1:0] new_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] lamp_levels_o
);

  lpf_pkg::item_t in_item;
  lpf_pkg::item_t held_item;
  logic           held_valid;
  logic           take;
  logic           out_valid_q, out_valid_d;

  assign in_item.kind        = lpf_pkg::kind_e'(kind_i);
  assign in_item.led_index   = led_index_i;
  assign in_item.alarm_level = alarm_level_i;
  assign in_item.new_mode    = new_mode_i;

  // The lamp bits register doubles as the result register, so a held word
  // advances only when the previous result is gone or leaving.
  assign take = held_valid && (!out_valid_q || !out_stall_i);

  lpf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  lpf_lamp_ctrl u_lamp_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .item_i      (held_item),
    .lamp_bits_o (lamp_levels_o)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/lpf_in_stage.sv
// Input register stage: captures one word and holds it until the lamp logic takes it.
// Depends on lpf_pkg for the word type.
module lpf_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lpf_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output lpf_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  lpf_pkg::item_t item_q;
  logic           accept;

  // The held word leaves in the same cycle that a new one may enter.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/lpf_lamp_ctrl.sv
// Lamp state and its update logic: pulse timers, flash phases, alarm mask and mode.
// Depends on lpf_pkg for types and constants.
module lpf_lamp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  lpf_pkg::item_t                 item_i,
  output logic [lpf_pkg::LAMP_COUNT-1:0] lamp_bits_o
);

  localparam lpf_pkg::tmo_t PULSE_TMO  = lpf_pkg::tmo_t'(lpf_pkg::PULSE_TICKS);
  localparam lpf_pkg::tmo_t STEADY_TMO = lpf_pkg::tmo_t'(-lpf_pkg::FLASH_PERIOD);
  localparam lpf_pkg::tmo_t PERIOD_TMO = lpf_pkg::tmo_t'(lpf_pkg::FLASH_PERIOD);
  localparam logic [lpf_pkg::MASK_W-1:0] BATTERY_MASK =
    lpf_pkg::MASK_W'(lpf_pkg::FLASH_PERIOD);

  lpf_pkg::tmo_t timeout_q [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t timeout_d [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t phase_q   [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t phase_d   [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t limit_q   [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t limit_d   [lpf_pkg::LAMP_COUNT];
  lpf_pkg::tmo_t phase_inc [lpf_pkg::LAMP_COUNT];

  logic [lpf_pkg::LAMP_COUNT-1:0] bits_q, bits_d;
  logic [lpf_pkg::MASK_W-1:0]     mask_q, mask_d;
  lpf_pkg::mode_e                 mode_q, mode_d;

  // One item writes at most one value to any set of lamps.
  logic [lpf_pkg::LAMP_COUNT-1:0] wr_en;
  logic                           wr_on;
  lpf_pkg::tmo_t                  wr_tmo;
  logic                           do_tick;
  logic                           normal;
  logic                           alarm_cur;
  int unsigned                    alarm_pos;

  assign normal = (mode_q == lpf_pkg::MODE_NORMAL);

  always_comb begin
    for (int i = 0; i < lpf_pkg::LAMP_COUNT; i++) begin
      phase_inc[i] = phase_q[i] + lpf_pkg::tmo_t'(1);
    end
  end

  // Decode the word into lamp writes, timer ticks and mask or mode changes.
  always_comb begin
    wr_en     = '0;
    wr_on     = 1'b0;
    wr_tmo    = '0;
    do_tick   = 1'b0;
    mask_d    = mask_q;
    mode_d    = mode_q;
    alarm_pos = (item_i.kind == lpf_pkg::KIND_GPS) ? lpf_pkg::GPS_BIT : lpf_pkg::MAIN_BIT;
    alarm_cur = mask_q[alarm_pos[1:0]];
    if (fire_i) begin
      case (item_i.kind)
        lpf_pkg::KIND_TICK: begin
          if (normal) begin
            do_tick = 1'b1;
          end else if (mode_q == lpf_pkg::MODE_DUMP) begin
            wr_en[lpf_pkg::DUMP_LAMP] = 1'b1;
            wr_on  = !bits_q[lpf_pkg::DUMP_LAMP];
            wr_tmo = PULSE_TMO;
          end
        end
        lpf_pkg::KIND_PULSE: begin
          wr_en[item_i.led_index] = normal;
          wr_on  = 1'b1;
          wr_tmo = PULSE_TMO;
        end
        lpf_pkg::KIND_STEADY: begin
          wr_en[item_i.led_index] = normal;
          wr_on  = 1'b1;
          wr_tmo = STEADY_TMO;
        end
        lpf_pkg::KIND_GPS, lpf_pkg::KIND_MAIN: begin
          if (alarm_cur != item_i.alarm_level) begin
            mask_d[alarm_pos[1:0]] = item_i.alarm_level;
            wr_en[lpf_pkg::ALARM_LAMP] = normal;
            wr_on  = 1'b1;
            wr_tmo = lpf_pkg::tmo_t'(-$signed({1'b0, mask_d}));
          end
        end
        lpf_pkg::KIND_BATTERY: begin
          if (!item_i.alarm_level) begin
            if (mask_q != '0) begin
              mask_d = '0;
              wr_en[lpf_pkg::ALARM_LAMP] = normal;
              wr_on  = 1'b1;
              wr_tmo = '0;
            end
          end else begin
            mask_d = BATTERY_MASK;
            wr_en[lpf_pkg::ALARM_LAMP] = normal;
            wr_on  = 1'b1;
            wr_tmo = lpf_pkg::tmo_t'(-$signed({1'b0, BATTERY_MASK}));
          end
        end
        lpf_pkg::KIND_SET_MODE: begin
          wr_on  = 1'b0;
          wr_tmo = PULSE_TMO;
          case (item_i.new_mode)
            lpf_pkg::MODE_NORMAL: begin
              mode_d = lpf_pkg::MODE_NORMAL;
            end
            lpf_pkg::MODE_DUMP: begin
              mode_d = lpf_pkg::MODE_DUMP;
              wr_en  = 4'b0111;
            end
            lpf_pkg::MODE_DONE: begin
              mode_d = lpf_pkg::MODE_DONE;
              wr_en[lpf_pkg::DUMP_LAMP] = 1'b1;
            end
            default: begin
              mode_d = mode_q;
            end
          endcase
        end
        default: begin
          do_tick = 1'b0;
        end
      endcase
    end
  end

  // Apply the writes or advance the per-lamp timers.
  always_comb begin
    for (int i = 0; i < lpf_pkg::LAMP_COUNT; i++) begin
      timeout_d[i] = timeout_q[i];
      phase_d[i]   = phase_q[i];
      limit_d[i]   = limit_q[i];
      bits_d[i]    = bits_q[i];
      if (wr_en[i]) begin
        bits_d[i]    = wr_on && (wr_tmo != '0);
        timeout_d[i] = wr_tmo;
        if (wr_tmo < 0) begin
          phase_d[i] = wr_tmo;
          limit_d[i] = PERIOD_TMO + wr_tmo;
        end
      end else if (do_tick) begin
        if (timeout_q[i] > 0) begin
          timeout_d[i] = timeout_q[i] - lpf_pkg::tmo_t'(1);
          if (timeout_d[i] == '0) begin
            bits_d[i] = 1'b0;
          end
        end else if (timeout_q[i] < 0) begin
          phase_d[i] = phase_inc[i];
          if (phase_inc[i] >= limit_q[i]) begin
            phase_d[i] = timeout_q[i];
            bits_d[i]  = 1'b1;
          end
          if (phase_d[i] == '0) begin
            bits_d[i] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lpf_pkg::LAMP_COUNT; i++) begin
        timeout_q[i] <= '0;
        phase_q[i]   <= '0;
        limit_q[i]   <= '0;
      end
      bits_q <= '0;
      mask_q <= '0;
      mode_q <= lpf_pkg::MODE_NORMAL;
    end else begin
      timeout_q <= timeout_d;
      phase_q   <= phase_d;
      limit_q   <= limit_d;
      bits_q    <= bits_d;
      mask_q    <= mask_d;
      mode_q    <= mode_d;
    end
  end

  assign lamp_bits_o = bits_q;

endmodule
